// ===== design/spd_pkg.sv =====
// Shared types and constants for the serial packet deframer.
package spd_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;
  localparam int LEN_W  = 7;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_POLL    = 1'b1;

  // Framing characters
  localparam logic [BYTE_W-1:0] HDR_BIN = 8'hFF;
  localparam logic [BYTE_W-1:0] TRL_BIN = 8'hFE;
  localparam logic [BYTE_W-1:0] HDR_TXT = 8'h40;
  localparam logic [BYTE_W-1:0] CR_TXT  = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_TXT  = 8'h0A;

  // Command handed from the parser to the result sequencer
  typedef struct packed {
    logic             poll;
    logic             flag;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } spd_cmd_t;

  // Frame store write port
  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } spd_wr_t;

endpackage

// ===== design/spd_ifs.sv =====
// Channel interfaces of the serial packet deframer.
interface spd_cfg_if;
  logic valid;
  logic ready;
  logic text_mode;
  modport source (output valid, output text_mode, input ready);
  modport sink (input valid, input text_mode, output ready);
endinterface

interface spd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface spd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [5:0] position;
  logic [6:0] frame_length;
  logic       overflow;
  logic       flag_was_set;
  logic       last;
  modport source (output valid, output kind, output payload_byte, output position,
                  output frame_length, output overflow, output flag_was_set,
                  output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input position,
                input frame_length, input overflow, input flag_was_set,
                input last, output ready);
endinterface

// ===== design/spd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/spd_front.sv =====
// Parser front end: takes beats, tracks framing, fills the frame store, queues commands.
module spd_front #(
  parameter int TEXT_DEPTH = 64,
  parameter int BIN_LEN    = 4
) (
  input  logic               clk,
  input  logic               rst,
  spd_cfg_if.sink            cfg,
  spd_in_if.sink             rx,
  output spd_pkg::spd_wr_t   wr,
  output logic               push,
  output spd_pkg::spd_cmd_t  push_cmd,
  input  logic               q_full,
  input  logic               frame_done
);
  import spd_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_TRAILER = 2'd2;

  localparam logic [LEN_W-1:0] TEXT_LIMIT = LEN_W'(TEXT_DEPTH);
  localparam logic [LEN_W-1:0] BIN_LIMIT  = LEN_W'(BIN_LEN);

  logic             text_mode, text_mode_next;
  logic [1:0]       phase, phase_next;
  logic [LEN_W-1:0] fill, fill_next;
  logic             done, done_next;
  logic             ovf, ovf_next;
  logic             busy, busy_next;
  logic             accept;
  logic [BYTE_W-1:0] b;

  assign cfg.ready = 1'b1;
  // Hold bytes while a finished frame still drains out of the store.
  assign rx.ready  = !q_full && (rx.op == OP_POLL || !busy);
  assign accept    = rx.valid && rx.ready;
  assign b         = rx.rx_byte;

  always_comb begin
    text_mode_next = text_mode;
    phase_next     = phase;
    fill_next      = fill;
    done_next      = done;
    ovf_next       = ovf;
    busy_next      = busy;
    push           = 1'b0;
    push_cmd       = '0;
    wr.en          = 1'b0;
    wr.addr        = fill[POS_W-1:0];
    wr.data        = b;

    if (frame_done) begin
      busy_next = 1'b0;
    end

    if (accept) begin
      if (rx.op == OP_POLL) begin
        push          = 1'b1;
        push_cmd.poll = 1'b1;
        push_cmd.flag = done;
        done_next     = 1'b0;
      end else begin
        case (phase)
          PH_COLLECT: begin
            if (text_mode) begin
              if (b == CR_TXT) begin
                phase_next = PH_TRAILER;
              end else if (fill < TEXT_LIMIT) begin
                wr.en     = 1'b1;
                fill_next = fill + LEN_W'(1);
              end else begin
                ovf_next = 1'b1;
              end
            end else begin
              wr.en     = 1'b1;
              fill_next = fill + LEN_W'(1);
              if (fill_next >= BIN_LIMIT) begin
                phase_next = PH_TRAILER;
              end
            end
          end
          PH_TRAILER: begin
            if (b == (text_mode ? LF_TXT : TRL_BIN)) begin
              phase_next   = PH_HEADER;
              done_next    = 1'b1;
              busy_next    = 1'b1;
              push         = 1'b1;
              push_cmd.len = fill;
              push_cmd.ovf = ovf;
            end
          end
          default: begin
            phase_next = PH_HEADER;
            if ((text_mode && b == HDR_TXT && !done) || (!text_mode && b == HDR_BIN)) begin
              phase_next = PH_COLLECT;
              fill_next  = '0;
              ovf_next   = 1'b0;
            end
          end
        endcase
      end
    end

    // A mode write restarts the parser but keeps the done flag.
    if (cfg.valid) begin
      text_mode_next = cfg.text_mode;
      phase_next     = PH_HEADER;
      fill_next      = '0;
      ovf_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_mode <= 1'b1;
      phase     <= PH_HEADER;
      fill      <= '0;
      done      <= 1'b0;
      ovf       <= 1'b0;
      busy      <= 1'b0;
    end else begin
      text_mode <= text_mode_next;
      phase     <= phase_next;
      fill      <= fill_next;
      done      <= done_next;
      ovf       <= ovf_next;
      busy      <= busy_next;
    end
  end

endmodule

// ===== design/spd_queue.sv =====
// Two-entry command queue between parser and result sequencer.
module spd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spd_pkg::spd_cmd_t push_cmd,
  input  logic              pop,
  output spd_pkg::spd_cmd_t head,
  output logic              empty,
  output logic              full
);
  import spd_pkg::*;

  spd_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/spd_back.sv =====
// Result sequencer: turns queued commands into result beats, reading the frame store.
module spd_back #(
  parameter int ADDR_W = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spd_pkg::spd_cmd_t    head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 rd_en,
  output logic [ADDR_W-1:0]    rd_addr,
  input  logic [7:0]           rd_data,
  spd_out_if.source            res,
  output logic                 frame_done
);
  import spd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  logic [1:0]       state;
  logic             kind;
  logic             flag;
  logic [LEN_W-1:0] len;
  logic             ovf;
  logic [POS_W-1:0] idx;
  logic             is_last;
  logic             has_data;

  assign pop      = (state == ST_IDLE) && !empty;
  assign rd_en    = (state == ST_READ);
  assign rd_addr  = idx[ADDR_W-1:0];
  assign has_data = (kind == KIND_PAYLOAD) && (len != '0);
  assign is_last  = !has_data || ({1'b0, idx} + 7'd1 == len);

  assign res.valid        = (state == ST_SHOW);
  assign res.kind         = kind;
  assign res.payload_byte = has_data ? rd_data : '0;
  assign res.position     = idx;
  assign res.frame_length = len;
  assign res.overflow     = ovf;
  assign res.flag_was_set = flag;
  assign res.last         = is_last;
  assign frame_done       = res.valid && res.ready && is_last && (kind == KIND_PAYLOAD);

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= head.poll ? KIND_POLL : KIND_PAYLOAD;
      flag <= head.flag;
      len  <= head.len;
      ovf  <= head.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            idx   <= '0;
            state <= (!head.poll && head.len != '0) ? ST_READ : ST_SHOW;
          end
        end
        ST_READ: begin
          state <= ST_SHOW;
        end
        ST_SHOW: begin
          if (res.ready) begin
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + POS_W'(1);
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/serial_packet_deframer.sv =====
// Top level of the serial packet deframer.
// The block turns received serial bytes into frames, in binary mode (0xFF, BIN_LEN
// payload bytes, 0xFE) or text mode ('@', bytes up to CR, then LF; a new text frame
// starts only while the done flag is clear). A poll beat answers with the done flag
// and clears it. The parser front end takes one beat per cycle unless it holds beats
// off as below, and writes payload bytes into a frame store RAM; finished frames and
// poll answers go through a two-entry command queue to a sequencer that plays them
// out. The sequencer plays out a finished frame one result byte at a time, each byte
// set by the registered RAM read followed by the output beat, which waits for the
// receiver to be ready, and it does not read the next byte before the last is taken; an
// empty text frame gives one result. While a frame drains, byte beats are held off
// (the store is being read), but poll beats are still taken until the queue is full.
// A write on the mode channel restarts the parser and keeps the done flag; it is
// taken at once.
module serial_packet_deframer #(
  parameter int TEXT_DEPTH = 64,
  parameter int BIN_LEN    = 4
) (
  input  logic      clk,
  input  logic      rst,
  spd_cfg_if.sink   cfg,
  spd_in_if.sink    rx,
  spd_out_if.source res
);
  import spd_pkg::*;

  // Store holds the longer of a text line and a binary payload.
  localparam int STORE_DEPTH = (TEXT_DEPTH > BIN_LEN) ? TEXT_DEPTH : BIN_LEN;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  spd_wr_t           wr;
  logic              push;
  spd_cmd_t          push_cmd;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  spd_cmd_t          head;
  logic              frame_done;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  spd_front #(
    .TEXT_DEPTH (TEXT_DEPTH),
    .BIN_LEN    (BIN_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rx         (rx),
    .wr         (wr),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full),
    .frame_done (frame_done)
  );

  // Frame store: written by the parser, read by the sequencer.
  spd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr[ADDR_W-1:0]),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  spd_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res        (res),
    .frame_done (frame_done)
  );

endmodule
